/* hdl/akrt_pkg.sv */
`default_nettype none

package akrt_pkg;

    // Field widths of the stream items.
    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int TRAVEL_W  = 12;
    localparam int CODE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int SLOT_IO_W = 3;
    localparam int HELD_IO_W = 3;

    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_TUSER_W  = 8;

    // Default matrix and report geometry.
    localparam int DEF_ROW_COUNT  = 8;
    localparam int DEF_COL_COUNT  = 16;
    localparam int DEF_SLOT_COUNT = 6;

    localparam logic [TRAVEL_W-1:0] THRESHOLD_RESET = 12'd64;

    typedef logic [KIND_W-1:0] t_event_kind;

    localparam t_event_kind EV_NONE     = 2'd0;
    localparam t_event_kind EV_PRESSED  = 2'd1;
    localparam t_event_kind EV_RELEASED = 2'd2;
    localparam t_event_kind EV_DROPPED  = 2'd3;

endpackage

`default_nettype wire

/* hdl/analog_key_rapid_trigger_slots.sv */
`default_nettype none

// Channel  | Signals                                  | Content (lowest bit first)
// ---------+------------------------------------------+---------------------------------------
// samples  | s_axis_tvalid/tready/tdata               | key_row, key_col, travel_sample,
//          |                                          | key_code
// events   | m_axis_tvalid/tready/tdata/tuser         | tdata: slot_index, slot_code,
//          |                                          | keys_held; tuser: event_kind
// config   | i_cfg_valid/o_cfg_ready/i_cfg_data       | travel_threshold
//
// One request is taken per cycle. Each request is first read from the key memory into the
// read stage registers and then passes the update, which writes the key entry back; a
// back-to-back request for the same key gets the fresh entry through a forwarding register.
// After reset a clearing pass writes every key entry to zero, one per cycle; no request is
// taken during that time. A stall on the event side holds the update stage and, once the
// output register is full, stops taking requests.

module analog_key_rapid_trigger_slots #(
    parameter int ROW_COUNT  = akrt_pkg::DEF_ROW_COUNT,
    parameter int COL_COUNT  = akrt_pkg::DEF_COL_COUNT,
    parameter int SLOT_COUNT = akrt_pkg::DEF_SLOT_COUNT
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // key_row, key_col, travel_sample, key_code
    input  wire  [akrt_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // slot_index, slot_code, keys_held
    output logic [akrt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // event_kind
    output logic [akrt_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [akrt_pkg::TRAVEL_W-1:0]         i_cfg_data
);
    import akrt_pkg::*;

    localparam int KEY_TOTAL = ROW_COUNT * COL_COUNT;
    localparam int KEY_W     = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;
    localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int HS_W      = $clog2(SLOT_COUNT + 1);
    localparam int ENT_W     = TRAVEL_W + HS_W;

    // Key memory: {held slot plus one, reference level}.
    logic [ENT_W-1:0] r_key_mem [KEY_TOTAL];

    logic [TRAVEL_W-1:0] r_threshold;
    logic                r_clr_busy;
    logic [KEY_W-1:0]    r_clr_addr;

    logic [ROW_W-1:0]    in_row;
    logic [COL_W-1:0]    in_col;
    logic [TRAVEL_W-1:0] in_travel;
    logic [CODE_W-1:0]   in_code;
    logic                in_hit;
    logic [31:0]         in_key_full;
    logic [KEY_W-1:0]    in_addr;
    logic                accept;

    logic                r_s1_valid;
    logic                r_s1_hit;
    logic [KEY_W-1:0]    r_s1_addr;
    logic [TRAVEL_W-1:0] r_s1_cur;
    logic [CODE_W-1:0]   r_s1_code;
    logic [ENT_W-1:0]    r_rd_data;
    logic                r_fwd_hit;
    logic [ENT_W-1:0]    r_fwd_data;
    logic                s1_fire;

    logic [SLOT_COUNT-1:0] r_slot_busy;
    logic [HS_W-1:0]       r_held_count;

    logic [ENT_W-1:0]    ent;
    logic [TRAVEL_W-1:0] ref_lvl;
    logic [HS_W-1:0]     hs;
    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;
    logic [HS_W-1:0]     rel_idx;

    logic [TRAVEL_W-1:0]   n_ref;
    logic [HS_W-1:0]       n_hs;
    logic [SLOT_COUNT-1:0] n_slot_busy;
    logic [HS_W-1:0]       n_held_count;
    t_event_kind           n_kind;
    logic [SLOT_W-1:0]     n_slot;
    logic [CODE_W-1:0]     n_scode;
    logic [ENT_W-1:0]      n_entry;

    logic                mem_we;
    logic [KEY_W-1:0]    mem_waddr;
    logic [ENT_W-1:0]    mem_wdata;

    logic                 r_out_valid;
    t_event_kind          r_out_kind;
    logic [SLOT_IO_W-1:0] r_out_slot;
    logic [CODE_W-1:0]    r_out_code;
    logic [HELD_IO_W-1:0] r_out_held;

    // Input side.
    assign in_row    = s_axis_tdata[ROW_W-1:0];
    assign in_col    = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_travel = s_axis_tdata[ROW_W+COL_W+TRAVEL_W-1:ROW_W+COL_W];
    assign in_code   = s_axis_tdata[ROW_W+COL_W+TRAVEL_W+CODE_W-1:ROW_W+COL_W+TRAVEL_W];

    assign in_hit = (in_code != '0) && (32'(in_row) < 32'(ROW_COUNT))
                    && (32'(in_col) < 32'(COL_COUNT));
    assign in_key_full = 32'(in_row) * 32'(COL_COUNT) + 32'(in_col);
    assign in_addr     = in_key_full[KEY_W-1:0];

    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_fire);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Configuration is taken at any time.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (32'(r_clr_addr) == KEY_TOTAL - 1) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + KEY_W'(1);
        end
    end

    // Key memory, one write and one registered read port.
    assign mem_we    = r_clr_busy || (s1_fire && r_s1_hit);
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign mem_wdata = r_clr_busy ? '0 : n_entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_key_mem[in_addr];
        end
    end

    // Read stage registers. The forwarding register catches the entry written back by
    // the request ahead at the same edge as this read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_hit   <= in_hit;
            r_s1_addr  <= in_addr;
            r_s1_cur   <= in_travel;
            r_s1_code  <= in_code;
            r_fwd_hit  <= s1_fire && r_s1_hit && (r_s1_addr == in_addr);
            r_fwd_data <= n_entry;
        end
    end

    // Update stage.
    assign ent     = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign ref_lvl = ent[TRAVEL_W-1:0];
    assign hs      = ent[ENT_W-1:TRAVEL_W];
    assign rel_idx = hs - HS_W'(1);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (!r_slot_busy[k]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
    end

    always_comb begin
        n_ref        = ref_lvl;
        n_hs         = hs;
        n_slot_busy  = r_slot_busy;
        n_held_count = r_held_count;
        n_kind       = EV_NONE;
        n_slot       = '0;
        n_scode      = '0;
        if (r_s1_hit) begin
            if (hs == '0) begin
                if (ref_lvl > r_s1_cur) begin
                    if ((ref_lvl - r_s1_cur) > r_threshold) begin
                        if ((32'(r_held_count) < 32'(SLOT_COUNT)) && free_found) begin
                            n_slot_busy[free_idx] = 1'b1;
                            n_hs                  = HS_W'(free_idx) + HS_W'(1);
                            n_held_count          = r_held_count + HS_W'(1);
                            n_kind                = EV_PRESSED;
                            n_slot                = free_idx;
                            n_scode               = r_s1_code;
                        end else begin
                            n_kind = EV_DROPPED;
                        end
                        n_ref = r_s1_cur;
                    end
                end else begin
                    n_ref = r_s1_cur;
                end
            end else begin
                if (ref_lvl >= r_s1_cur) begin
                    n_ref = r_s1_cur;
                end else if ((r_s1_cur - ref_lvl) > r_threshold) begin
                    // A stored slot that is out of range only clears the key.
                    if ((r_held_count != '0) && (32'(rel_idx) < 32'(SLOT_COUNT))) begin
                        n_slot_busy[rel_idx[SLOT_W-1:0]] = 1'b0;
                        n_held_count = r_held_count - HS_W'(1);
                        n_kind       = EV_RELEASED;
                        n_slot       = rel_idx[SLOT_W-1:0];
                    end
                    n_hs  = '0;
                    n_ref = r_s1_cur;
                end
            end
        end
        n_entry = {n_hs, n_ref};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_busy  <= '0;
            r_held_count <= '0;
        end else if (s1_fire) begin
            r_slot_busy  <= n_slot_busy;
            r_held_count <= n_held_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_kind <= n_kind;
            r_out_slot <= SLOT_IO_W'(n_slot);
            r_out_code <= n_scode;
            r_out_held <= HELD_IO_W'(n_held_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_held, r_out_code, r_out_slot});
    assign m_axis_tuser  = OUT_TUSER_W'(r_out_kind);

endmodule

`default_nettype wire
